[rtl/gfba_pkg.sv]
// Shared types and constants of the grouped free block allocator.
`timescale 1ns / 1ps
package gfba_pkg;

  localparam int unsigned BLK_W         = 10;
  localparam int unsigned CNT_OUT_W     = 5;
  localparam int unsigned GRP_ENTRIES_D = 16;
  localparam int unsigned NUM_BLOCKS_D  = 1024;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } gfba_state_e;

  // Link slot of a group: the block that holds the next full group.
  typedef struct packed {
    logic             present;
    logic [BLK_W-1:0] blk;
  } link_t;

  // Memory strobes from the controller to the store.
  typedef struct packed {
    logic rd_en;
    logic list_we;
    logic link_we;
  } mem_ctl_t;

  // One result of the block.
  typedef struct packed {
    logic [BLK_W-1:0]     granted_block;
    logic                 success;
    logic [CNT_OUT_W-1:0] head_group_count;
  } res_t;

endpackage

[rtl/grouped_free_block_allocator_core.sv]
// Top level of the grouped free block allocator: controller, store and result register.
`timescale 1ns / 1ps
// This block manages free block numbers with the classic grouped free list. An
// allocate request (kind 0) pops the newest entry of the head group; when that group
// runs empty, the next full group named by its link becomes the head, and when there
// is none the list is empty and further allocates fail with success low. A free
// request (kind 1) pushes the block onto the head group, or starts a new head group
// inside the freed block when the head group is full or the list is empty. Frees of
// block numbers at or above NUM_BLOCKS are refused. After reset the list is empty and
// software must free every block it wants managed; the store needs no clearing pass,
// so the block takes requests right after reset. In the accept cycle the store RAMs
// are read at the head group; in the execute state that follows, the head registers
// are updated, the store is written back and the result is loaded into the output
// register. The result register decouples the output side; a request only holds in
// its execute state while an earlier result is still not taken. Double frees are
// not detected and may hand out a block twice.
module grouped_free_block_allocator_core
  import gfba_pkg::*;
#(
  parameter int unsigned GRP_ENTRIES = GRP_ENTRIES_D,
  parameter int unsigned NUM_BLOCKS  = NUM_BLOCKS_D
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [BLK_W-1:0]     block_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BLK_W-1:0]     granted_block_o,
  output logic                 success_o,
  output logic [CNT_OUT_W-1:0] head_group_count_o
);

  localparam int unsigned STORE_BLKS = (NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024;
  localparam int unsigned IDX_W      = $clog2(STORE_BLKS);
  localparam int unsigned SLOT_W     = $clog2(GRP_ENTRIES);

  mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]  rd_blk;
  logic [SLOT_W-1:0] rd_slot;
  logic [IDX_W-1:0]  list_wr_blk;
  logic [SLOT_W-1:0] list_wr_slot;
  logic [BLK_W-1:0]  list_wr_data;
  logic [IDX_W-1:0]  link_wr_blk;
  link_t             link_wr_data;
  logic [BLK_W-1:0]  list_rd_data;
  link_t             link_rd_data;

  logic              res_valid;
  res_t              res;
  logic              res_free;

  logic              out_valid_q, out_valid_d;
  res_t              out_q;

  // The result register is free when empty or when its content leaves this cycle.
  assign res_free = !out_valid_q || out_ready_i;

  gfba_ctrl #(
    .GRP_ENTRIES (GRP_ENTRIES),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (in_valid_i),
    .req_ready_o    (in_ready_o),
    .kind_i         (kind_i),
    .block_i        (block_i),
    .res_free_i     (res_free),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .mem_o          (mem_ctl),
    .rd_blk_o       (rd_blk),
    .rd_slot_o      (rd_slot),
    .list_wr_blk_o  (list_wr_blk),
    .list_wr_slot_o (list_wr_slot),
    .list_wr_data_o (list_wr_data),
    .link_wr_blk_o  (link_wr_blk),
    .link_wr_data_o (link_wr_data),
    .list_rd_data_i (list_rd_data),
    .link_rd_data_i (link_rd_data)
  );

  gfba_store #(
    .GRP_ENTRIES (GRP_ENTRIES),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_store (
    .clk_i          (clk_i),
    .ctl_i          (mem_ctl),
    .rd_blk_i       (rd_blk),
    .rd_slot_i      (rd_slot),
    .list_wr_blk_i  (list_wr_blk),
    .list_wr_slot_i (list_wr_slot),
    .list_wr_data_i (list_wr_data),
    .link_wr_blk_i  (link_wr_blk),
    .link_wr_data_i (link_wr_data),
    .list_rd_data_o (list_rd_data),
    .link_rd_data_o (link_rd_data)
  );

  // Output register: loaded whenever the controller finishes a request.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign granted_block_o    = out_q.granted_block;
  assign success_o          = out_q.success;
  assign head_group_count_o = out_q.head_group_count;

  // An accepted request occupies the controller, which then shows itself not ready.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o
  ) else $error("request accepted in the cycle after an accept");

  // A failed request never hands out a block.
  a_fail_no_grant: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !success_o |-> granted_block_o == '0
  ) else $error("block number shown on a failed request");

  // With the output side empty, a result is registered from the execute state.
  a_result_latency: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 out_valid_o
  ) else $error("result of a request did not arrive in time");

endmodule

[rtl/gfba_store.sv]
// Group store: list RAM and link RAM, synchronous (registered) read.
`timescale 1ns / 1ps
module gfba_store
  import gfba_pkg::*;
#(
  parameter int unsigned GRP_ENTRIES = GRP_ENTRIES_D,
  parameter int unsigned NUM_BLOCKS  = NUM_BLOCKS_D
) (
  input  logic                                            clk_i,
  input  mem_ctl_t                                        ctl_i,
  input  logic [$clog2((NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024)-1:0] rd_blk_i,
  input  logic [$clog2(GRP_ENTRIES)-1:0]                  rd_slot_i,
  input  logic [$clog2((NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024)-1:0] list_wr_blk_i,
  input  logic [$clog2(GRP_ENTRIES)-1:0]                  list_wr_slot_i,
  input  logic [BLK_W-1:0]                                list_wr_data_i,
  input  logic [$clog2((NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024)-1:0] link_wr_blk_i,
  input  link_t                                           link_wr_data_i,
  output logic [BLK_W-1:0]                                list_rd_data_o,
  output link_t                                           link_rd_data_o
);

  localparam int unsigned STORE_BLKS = (NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024;
  localparam int unsigned IDX_W      = $clog2(STORE_BLKS);
  localparam int unsigned SLOT_W     = $clog2(GRP_ENTRIES);
  localparam int unsigned LIST_DEPTH = 2 ** (IDX_W + SLOT_W);
  localparam int unsigned LINK_DEPTH = 2 ** IDX_W;

  logic [BLK_W-1:0] list_mem [LIST_DEPTH];
  link_t            link_mem [LINK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.list_we) begin
      list_mem[{list_wr_blk_i, list_wr_slot_i}] <= list_wr_data_i;
    end
    if (ctl_i.rd_en) begin
      list_rd_data_o <= list_mem[{rd_blk_i, rd_slot_i}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.link_we) begin
      link_mem[link_wr_blk_i] <= link_wr_data_i;
    end
    if (ctl_i.rd_en) begin
      link_rd_data_o <= link_mem[rd_blk_i];
    end
  end

endmodule

[rtl/gfba_ctrl.sv]
// Controller: head group registers, request sequencer and store updates.
`timescale 1ns / 1ps
module gfba_ctrl
  import gfba_pkg::*;
#(
  parameter int unsigned GRP_ENTRIES = GRP_ENTRIES_D,
  parameter int unsigned NUM_BLOCKS  = NUM_BLOCKS_D
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            req_valid_i,
  output logic                                            req_ready_o,
  input  logic                                            kind_i,
  input  logic [BLK_W-1:0]                                block_i,
  input  logic                                            res_free_i,
  output logic                                            res_valid_o,
  output res_t                                            res_o,
  output mem_ctl_t                                        mem_o,
  output logic [$clog2((NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024)-1:0] rd_blk_o,
  output logic [$clog2(GRP_ENTRIES)-1:0]                  rd_slot_o,
  output logic [$clog2((NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024)-1:0] list_wr_blk_o,
  output logic [$clog2(GRP_ENTRIES)-1:0]                  list_wr_slot_o,
  output logic [BLK_W-1:0]                                list_wr_data_o,
  output logic [$clog2((NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024)-1:0] link_wr_blk_o,
  output link_t                                           link_wr_data_o,
  input  logic [BLK_W-1:0]                                list_rd_data_i,
  input  link_t                                           link_rd_data_i
);

  localparam int unsigned STORE_BLKS = (NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024;
  localparam int unsigned IDX_W      = $clog2(STORE_BLKS);
  localparam int unsigned SLOT_W     = $clog2(GRP_ENTRIES);
  localparam int unsigned CNT_W      = $clog2(GRP_ENTRIES + 1);

  gfba_state_e       state_q, state_d;
  logic [BLK_W-1:0]  head_q, head_d;
  logic              present_q, present_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              kind_q;
  logic [BLK_W-1:0]  blk_q;

  logic              accept;
  logic              exec;
  logic [CNT_W-1:0]  cnt_dec;
  logic              new_group;
  logic              blk_ok;
  logic [CNT_W+4:0]  cnt_ext;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign exec        = (state_q == ST_EXEC) && res_free_i;
  assign cnt_dec     = count_q - CNT_W'(1);
  assign new_group   = !present_q || (count_q == '0) || (count_q >= CNT_W'(GRP_ENTRIES));
  assign blk_ok      = (32'(blk_q) < NUM_BLOCKS);
  assign cnt_ext     = (CNT_W + 5)'(count_d);

  // Reads are issued with the request: the newest list entry and the link.
  assign rd_blk_o  = head_q[IDX_W-1:0];
  assign rd_slot_o = cnt_dec[SLOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      present_q <= 1'b0;
      count_q   <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      present_q <= present_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      blk_q  <= block_i;
    end
  end

  always_comb begin
    state_d        = state_q;
    head_d         = head_q;
    present_d      = present_q;
    count_d        = count_q;
    mem_o          = '0;
    mem_o.rd_en    = accept;
    list_wr_blk_o  = head_q[IDX_W-1:0];
    list_wr_slot_o = count_q[SLOT_W-1:0];
    list_wr_data_o = blk_q;
    link_wr_blk_o  = blk_q[IDX_W-1:0];
    link_wr_data_o.present = present_q && (count_q != '0);
    link_wr_data_o.blk     = head_q;
    res_valid_o    = 1'b0;
    res_o          = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec) begin
          state_d     = ST_IDLE;
          res_valid_o = 1'b1;
          if (kind_q == KIND_ALLOC) begin
            if (present_q && (count_q != '0)) begin
              res_o.success       = 1'b1;
              res_o.granted_block = list_rd_data_i;
              count_d             = cnt_dec;
              if (cnt_dec == '0) begin
                if (link_rd_data_i.present) begin
                  head_d  = link_rd_data_i.blk;
                  count_d = CNT_W'(GRP_ENTRIES);
                end else begin
                  head_d    = '0;
                  present_d = 1'b0;
                end
              end
            end
          end else if (blk_ok) begin
            res_o.success = 1'b1;
            mem_o.list_we = 1'b1;
            if (new_group) begin
              // The freed block becomes the new head group and links to the old one.
              list_wr_blk_o  = blk_q[IDX_W-1:0];
              list_wr_slot_o = '0;
              mem_o.link_we  = 1'b1;
              head_d         = blk_q;
              present_d      = 1'b1;
              count_d        = CNT_W'(1);
            end else begin
              count_d = count_q + CNT_W'(1);
            end
          end
          res_o.head_group_count = cnt_ext[CNT_OUT_W-1:0];
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
